[hw/rtl/fed_pkg.sv]
// ----------------------------------------------------------------------------
// Feedback echo delay package
// Shared widths, constants, register indexes and the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package fed_pkg;

  // Line and converter geometry.
  localparam int DELAY_DEPTH = 131072;
  localparam int SAMPLE_RATE = 48000;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int CNT_W       = (ADDR_W > 1) ? $clog2(ADDR_W) : 1;

  // Field and register widths.
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 16;
  localparam int TIME_W   = 11;
  localparam int BEAT_W   = 10;
  localparam int BPM_W    = 9;
  localparam int GAIN_W   = 16;

  // Delay in samples is num / den.
  // Millisecond mode: time_ms * SAMPLE_RATE / 1000.
  // Sync mode: 240 * beat_time * SAMPLE_RATE / (256 * bpm), reduced by 16.
  localparam longint SYNC_K       = longint'(SAMPLE_RATE) * 15;
  localparam longint SYNC_DEN_K   = 16;
  localparam longint MS_DEN       = 1000;
  localparam longint NUM_MAX_MS   = ((longint'(1) << TIME_W) - 1) * longint'(SAMPLE_RATE);
  localparam longint NUM_MAX_SYNC = ((longint'(1) << BEAT_W) - 1) * SYNC_K;
  localparam longint NUM_MAX      = (NUM_MAX_MS > NUM_MAX_SYNC) ? NUM_MAX_MS : NUM_MAX_SYNC;
  localparam int     NUM_W        = $clog2(NUM_MAX + 1);
  localparam longint DEN_MAX_SYNC = ((longint'(1) << BPM_W) - 1) * SYNC_DEN_K;
  localparam longint DEN_MAX      = (DEN_MAX_SYNC > MS_DEN) ? DEN_MAX_SYNC : MS_DEN;
  localparam int     DEN_W        = $clog2(DEN_MAX + 1);

  // Shared multiplier and datapath widths.
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SAT_W  = 24;
  localparam int COEF_W = 15;

  // 0.3 in Q0.16, rounded to nearest.
  localparam logic [COEF_W-1:0] COEF_POINT_THREE = 15'd19661;
  // 1.0 in Q0.16.
  localparam logic [GAIN_W:0]   GAIN_ONE         = 17'h1_0000;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_BYPASS        = 3'd0;
  localparam logic [IDX_W-1:0] REG_TEMPO_SYNC    = 3'd1;
  localparam logic [IDX_W-1:0] REG_TIME_MS       = 3'd2;
  localparam logic [IDX_W-1:0] REG_BEAT_TIME     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BPM           = 3'd4;
  localparam logic [IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd5;
  localparam logic [IDX_W-1:0] REG_WET_MIX       = 3'd6;
  localparam logic [IDX_W-1:0] REG_FILTER_AMOUNT = 3'd7;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32767);
    lo = -SAT_W'(32768);
    if (v > hi) begin
      return 16'sh7fff;
    end else if (v < lo) begin
      return 16'sh8000;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/feedback_echo_delay.sv]
// ----------------------------------------------------------------------------
// Feedback echo delay
// Echo with a circular delay line and a one-pole lowpass in the feedback path.
// ----------------------------------------------------------------------------
// Each transaction carries one signed Q1.15 sample and produces one mixed
// sample. A non-bypassed sample steps through the states NUM, PRE, DIV,
// ADDR, RD, FLT, FE, FBM, WRITE, MIX, SUM and OUT. The delay-length divider
// in DIV retires one quotient bit per cycle; the work also takes five passes
// through the single shared 18x18 multiplier and one read and one write of
// the delay memory. In bypass a sample goes from idle straight to OUT.
// in_stall is high while a sample is being worked on. The finished sample
// waits in the output register, and the next transaction is taken meanwhile.
// The delay memory needs no clearing after reset: a write-pointer wrap flag
// makes entries not yet written read as zero.
module feedback_echo_delay (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fed_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fed_pkg::SAMPLE_W-1:0]  out_sample,
  input  logic                                 wr_en,
  input  logic        [fed_pkg::IDX_W-1:0]     wr_index,
  input  logic        [fed_pkg::CFG_W-1:0]     wr_data
);
  import fed_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NUM   = 4'd1;
  localparam logic [3:0] S_PRE   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_FLT   = 4'd6;
  localparam logic [3:0] S_FE    = 4'd7;
  localparam logic [3:0] S_FBM   = 4'd8;
  localparam logic [3:0] S_WRITE = 4'd9;
  localparam logic [3:0] S_MIX   = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // Configuration registers.
  logic                bypass;
  logic                tempo_sync;
  logic [TIME_W-1:0]   time_ms;
  logic [BEAT_W-1:0]   beat_time;
  logic [BPM_W-1:0]    bpm;
  logic [GAIN_W-1:0]   feedback_gain;
  logic [GAIN_W-1:0]   wet_mix;
  logic [GAIN_W-1:0]   filter_amount;

  logic [3:0]                  state;
  logic [CNT_W-1:0]            cnt;
  logic signed [SAMPLE_W-1:0]  x;
  logic [NUM_W-1:0]            num;
  logic [DEN_W-1:0]            den;
  logic [DEN_W-1:0]            rem;
  logic [ADDR_W-1:0]           nlow;
  logic [ADDR_W-1:0]           quo;
  logic                        clamp;
  logic [COEF_W-1:0]           coef;
  logic [ADDR_W-1:0]           wp;
  logic                        wrapped;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        rd_ok;
  logic signed [SAMPLE_W-1:0]  rdata;
  logic signed [SAMPLE_W-1:0]  delayed;
  logic signed [SAMPLE_W-1:0]  fe;
  logic signed [PROD_W-1:0]    acc;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SAMPLE_W-1:0]  y;

  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic [DEN_W:0]              trial;
  logic                        trial_ge;
  logic [ADDR_W-1:0]           dly;
  logic [ADDR_W:0]             diff;
  logic [ADDR_W:0]             rd_wide;
  logic [ADDR_W-1:0]           rd_now;
  logic signed [SAMPLE_W-1:0]  delayed_now;
  logic signed [SAMPLE_W-1:0]  written;
  logic                        mem_we;

  logic signed [SAMPLE_W-1:0]  delay_store [DELAY_DEPTH];

  assign in_stall = (state != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass        <= 1'b0;
      tempo_sync    <= 1'b0;
      time_ms       <= 11'd500;
      beat_time     <= 10'd64;
      bpm           <= 9'd120;
      feedback_gain <= 16'd32768;
      wet_mix       <= 16'd32768;
      filter_amount <= 16'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BYPASS:        bypass        <= wr_data[0];
        REG_TEMPO_SYNC:    tempo_sync    <= wr_data[0];
        REG_TIME_MS:       time_ms       <= wr_data[TIME_W-1:0];
        REG_BEAT_TIME:     beat_time     <= wr_data[BEAT_W-1:0];
        REG_BPM:           bpm           <= wr_data[BPM_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain <= wr_data[GAIN_W-1:0];
        REG_WET_MIX:       wet_mix       <= wr_data[GAIN_W-1:0];
        REG_FILTER_AMOUNT: filter_amount <= wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // One restoring division step on the partial remainder.
  assign trial    = {rem, nlow[ADDR_W-1]};
  assign trial_ge = (trial >= {1'b0, den});

  // Clamp the quotient and place the read index behind the write pointer.
  assign dly     = (clamp || (quo > ADDR_W'(DELAY_DEPTH - 1))) ? ADDR_W'(DELAY_DEPTH - 1) : quo;
  assign diff    = {1'b0, wp} - {1'b0, dly};
  assign rd_wide = diff[ADDR_W] ? (diff + (ADDR_W + 1)'(DELAY_DEPTH)) : diff;
  assign rd_now  = rd_wide[ADDR_W-1:0];

  assign delayed_now = rd_ok ? rdata : '0;
  assign written     = sat16(SAT_W'(prod >>> 16) + SAT_W'(x));
  assign mem_we      = (state == S_WRITE);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_NUM: begin
        mul_a = MUL_W'(COEF_POINT_THREE);
        mul_b = MUL_W'(GAIN_ONE - {1'b0, filter_amount});
      end
      S_FLT: begin
        mul_a = MUL_W'(delayed_now) - MUL_W'(fe);
        mul_b = MUL_W'(coef);
      end
      S_FBM: begin
        mul_a = MUL_W'(fe);
        mul_b = MUL_W'(feedback_gain);
      end
      S_WRITE: begin
        mul_a = MUL_W'(x);
        mul_b = MUL_W'(GAIN_ONE - {1'b0, wet_mix});
      end
      S_MIX: begin
        mul_a = MUL_W'(delayed);
        mul_b = MUL_W'(wet_mix);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Delay memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      delay_store[wp] <= written;
    end
    rdata <= delay_store[rd_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x <= in_sample;
        y <= in_sample;
      end
      S_NUM: begin
        num <= tempo_sync ? NUM_W'(NUM_W'(beat_time) * NUM_W'(SYNC_K))
                          : NUM_W'(NUM_W'(time_ms) * NUM_W'(SAMPLE_RATE));
        den <= tempo_sync ? DEN_W'(DEN_W'(bpm) * DEN_W'(SYNC_DEN_K)) : DEN_W'(MS_DEN);
      end
      S_PRE: begin
        coef  <= COEF_W'(prod >>> 16);
        // A quotient that cannot fit the address width is clamped outright.
        // A zero tempo lands here as well.
        clamp <= ((num >> ADDR_W) >= NUM_W'(den));
        rem   <= DEN_W'(num >> ADDR_W);
        nlow  <= num[ADDR_W-1:0];
        quo   <= '0;
      end
      S_DIV: begin
        rem  <= trial_ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        nlow <= nlow << 1;
        quo  <= (quo << 1) | ADDR_W'(trial_ge);
      end
      S_ADDR: begin
        rd_addr <= rd_now;
        // An entry is unwritten until the write pointer has passed it once.
        rd_ok   <= wrapped || (rd_now < wp);
      end
      S_FLT: begin
        delayed <= delayed_now;
      end
      S_SUM: begin
        y <= sat16(SAT_W'((acc + prod) >>> 16));
      end
      S_MIX: begin
        acc <= prod;
      end
      default: ;
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      wp        <= '0;
      wrapped   <= 1'b0;
      fe        <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= bypass ? S_OUT : S_NUM;
          end
        end
        S_NUM: state <= S_PRE;
        S_PRE: begin
          cnt   <= CNT_W'(ADDR_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_ADDR;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_ADDR: state <= S_RD;
        S_RD:   state <= S_FLT;
        S_FLT:  state <= S_FE;
        S_FE: begin
          fe    <= sat16(SAT_W'(prod >>> 16) + SAT_W'(fe));
          state <= S_FBM;
        end
        S_FBM:  state <= S_WRITE;
        S_WRITE: begin
          if (wp == ADDR_W'(DELAY_DEPTH - 1)) begin
            wp      <= '0;
            wrapped <= 1'b1;
          end else begin
            wp <= wp + 1'b1;
          end
          state <= S_MIX;
        end
        S_MIX:  state <= S_SUM;
        S_SUM:  state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      out_sample <= y;
    end
  end

endmodule

[hw/rtl/fed_checker.sv]
// ----------------------------------------------------------------------------
// Feedback echo delay checker
// Port-level checks on transaction sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module fed_port_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [fed_pkg::SAMPLE_W-1:0]  out_sample
);
  import fed_pkg::*;

  // The block works on one sample at a time, so it is busy right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a sample was still in flight");

  // Reset empties the output register.
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A result appears only as the sequencer leaves its final, busy state.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample)))
    else $error("stalled output changed");

endmodule

bind feedback_echo_delay fed_port_checker u_fed_checker (.*);
